@@ rtl/aifp_pkg.sv @@
// types and constants shared by the ascii integer field parser
// no dependencies
package aifp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MINUS,
        PH_SIGN,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

    localparam int VALUE_W    = 64;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_OCT  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_NO_FIELD  = 2'd2;

    localparam logic [1:0] SIZE_16     = 2'd0;
    localparam logic [1:0] SIZE_32     = 2'd1;
    localparam logic [1:0] SIZE_64     = 2'd2;
    // spare code, kept at full width
    localparam logic [1:0] SIZE_64_ALT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GIVEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_CONV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_SIZE = 3'd4;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] NO_DIGIT   = 8'hff;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] stop_char;
        logic       stop_is_end;
        logic       negative;
    } t_emit_req;

endpackage

@@ rtl/aifp_accum.sv @@
// digit decode and multiply-accumulate with saturation for one character
// depends on aifp_pkg
module aifp_accum #(
    parameter int VALUE_BITS = 64
) (
    input  logic [VALUE_BITS-1:0] i_acc,
    input  logic [4:0]            i_base,
    input  logic [7:0]            i_char,
    output logic                  o_digit_ok,
    output logic [VALUE_BITS-1:0] o_acc
);

    localparam int SUM_W = VALUE_BITS + 4;

    logic [7:0]       w_low;
    logic [7:0]       w_digit;
    logic [SUM_W-1:0] w_dext;
    logic [SUM_W-1:0] w_sum;
    logic             w_ovf;

    always_comb begin
        w_low = i_char | aifp_pkg::CASE_BIT;
        if (w_low >= aifp_pkg::CH_LOWER_A) begin
            w_digit = w_low - aifp_pkg::CH_LOWER_A + 8'd10;
        end else if (i_char >= aifp_pkg::CH_ZERO && i_char <= aifp_pkg::CH_NINE) begin
            w_digit = i_char - aifp_pkg::CH_ZERO;
        end else begin
            w_digit = aifp_pkg::NO_DIGIT;
        end
    end

    assign o_digit_ok = {3'b000, i_base} > w_digit;
    assign w_dext     = {{(SUM_W-4){1'b0}}, w_digit[3:0]};

    // acc * base + digit, shifts and adds only
    always_comb begin
        case (i_base)
            aifp_pkg::BASE_OCT: w_sum = {1'b0, i_acc, 3'b000} + w_dext;
            aifp_pkg::BASE_HEX: w_sum = {i_acc, 4'b0000} + w_dext;
            default:            w_sum = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + w_dext;
        endcase
    end

    assign w_ovf = |w_sum[SUM_W-1:VALUE_BITS];
    assign o_acc = w_ovf ? {VALUE_BITS{1'b1}} : w_sum[VALUE_BITS-1:0];

endmodule

@@ rtl/aifp_final.sv @@
// result finishing: signed saturation, negation and truncation to result size
// depends on aifp_pkg
module aifp_final #(
    parameter int VALUE_BITS = 64
) (
    input  logic [VALUE_BITS-1:0]       i_acc,
    input  aifp_pkg::t_emit_req         i_req,
    input  logic                        i_signed,
    input  logic [1:0]                  i_size,
    output logic [aifp_pkg::VALUE_W-1:0] o_value
);

    logic [VALUE_BITS-1:0]        w_neg;
    logic [VALUE_BITS-1:0]        w_v;
    logic [aifp_pkg::VALUE_W-1:0] w_ext;

    assign w_neg = {VALUE_BITS{1'b0}} - i_acc;

    always_comb begin
        if (i_req.status != aifp_pkg::ST_OK) begin
            w_v = '0;
        end else if (i_signed && i_acc[VALUE_BITS-1]) begin
            w_v = i_req.negative ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                 : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else if (i_signed && i_req.negative) begin
            w_v = w_neg;
        end else begin
            w_v = i_acc;
        end
    end

    assign w_ext = aifp_pkg::VALUE_W'(w_v);

    always_comb begin
        case (i_size)
            aifp_pkg::SIZE_16: o_value = {48'd0, w_ext[15:0]};
            aifp_pkg::SIZE_32: o_value = {32'd0, w_ext[31:0]};
            default:           o_value = w_ext;
        endcase
    end

endmodule

@@ rtl/ascii_integer_field_parser.sv @@
// ascii integer field parser top level: input register, field state machine,
// result request register and output register
// depends on aifp_pkg, aifp_accum, aifp_final
//
// Slave side takes one character word per cycle: tdata[7:0] is the character,
// tlast marks end of input (the character is then ignored). Master side gives
// one word when a field ends: tdata holds the value then the stop character,
// tuser holds the status then the stop-is-end flag.
// Configuration is a plain write port (enable, register index, data); writes
// take effect on the next clock edge; the user is to make them only while the
// block is idle, as the block itself does not enforce it. Throughput is one
// character per cycle unless the master side stalls. The field logic feeds the
// request register, the finishing stage the output register. The whole
// accumulate step of one character, digit decode plus times-base and add, sits
// between the input register and the request register; signed saturation and
// negation sit in the finishing stage.
// A stalled master side fills the output, request and input registers in turn,
// after which tready on the slave side drops; nothing is lost.
// Synchronous reset empties all three registers, returns the field state to
// whitespace skipping and loads the register reset values.
module ascii_integer_field_parser #(
    parameter int VALUE_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,   // [7:0] char_in
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [aifp_pkg::OUT_DATA_W-1:0]      o_m_tdata,   // [63:0] value, [71:64] stop_char
    output logic [aifp_pkg::OUT_USER_W-1:0]      o_m_tuser,   // [1:0] status, [2] stop_is_end
    input  logic                                 i_cfg_we,
    input  logic [aifp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [aifp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration
    logic [1:0] r_base_mode;
    logic       r_width_given;
    logic [7:0] r_field_width;
    logic       r_signed_conv;
    logic [1:0] r_result_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mode   <= aifp_pkg::MODE_DEC;
            r_width_given <= 1'b0;
            r_field_width <= 8'd0;
            r_signed_conv <= 1'b1;
            r_result_size <= aifp_pkg::SIZE_32;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aifp_pkg::REG_BASE_MODE:   r_base_mode   <= i_cfg_data[1:0];
                aifp_pkg::REG_WIDTH_GIVEN: r_width_given <= i_cfg_data[0];
                aifp_pkg::REG_FIELD_WIDTH: r_field_width <= i_cfg_data;
                aifp_pkg::REG_SIGNED_CONV: r_signed_conv <= i_cfg_data[0];
                aifp_pkg::REG_RESULT_SIZE: r_result_size <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic r_in_valid;
    logic r_em_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_em_free;
    logic w_in_adv;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_em_free  = !r_em_valid || w_out_free;
    assign w_in_adv   = r_in_valid && w_em_free;
    assign o_s_tready = !r_in_valid || w_em_free;

    // input register
    logic [7:0] r_in_char;
    logic       r_in_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_eof  <= i_s_tlast;
        end
    end

    // field state
    aifp_pkg::t_phase      r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [4:0]            r_base, n_base;
    logic [7:0]            r_wleft, n_wleft;
    logic                  r_any, n_any;
    logic                  r_limited, n_limited;

    logic [VALUE_BITS-1:0] w_acc_cur;
    logic [VALUE_BITS-1:0] w_acc_next;
    logic [4:0]            w_base_mode;
    logic [4:0]            w_base_cur;
    logic                  w_digit_ok;
    logic                  w_space;
    logic                  w_do_begin;
    logic                  w_do_step;
    logic                  w_emit;
    aifp_pkg::t_emit_req   w_req;

    always_comb begin
        case (r_base_mode)
            aifp_pkg::MODE_OCT: w_base_mode = aifp_pkg::BASE_OCT;
            aifp_pkg::MODE_HEX: w_base_mode = aifp_pkg::BASE_HEX;
            default:            w_base_mode = aifp_pkg::BASE_DEC;
        endcase
    end

    assign w_base_cur = (r_phase == aifp_pkg::PH_IDLE) ? w_base_mode : r_base;
    assign w_acc_cur  = (r_phase == aifp_pkg::PH_IDLE) ? '0 : r_acc;
    assign w_space    = (r_in_char == aifp_pkg::CH_SPACE) ||
                        (r_in_char >= aifp_pkg::CH_TAB && r_in_char <= aifp_pkg::CH_CR);

    aifp_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .i_acc      (w_acc_cur),
        .i_base     (w_base_cur),
        .i_char     (r_in_char),
        .o_digit_ok (w_digit_ok),
        .o_acc      (w_acc_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= aifp_pkg::PH_IDLE;
            r_neg     <= 1'b0;
            r_acc     <= '0;
            r_base    <= aifp_pkg::BASE_DEC;
            r_wleft   <= 8'd0;
            r_any     <= 1'b0;
            r_limited <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            r_base    <= n_base;
            r_wleft   <= n_wleft;
            r_any     <= n_any;
            r_limited <= n_limited;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_base     = r_base;
        n_wleft    = r_wleft;
        n_any      = r_any;
        n_limited  = r_limited;
        w_do_begin = 1'b0;
        w_do_step  = 1'b0;
        w_emit     = 1'b0;
        w_req      = '0;
        if (w_in_adv) begin
            case (r_phase)
                aifp_pkg::PH_IDLE: begin
                    if (r_in_eof) begin
                        w_emit            = 1'b1;
                        w_req.status      = aifp_pkg::ST_NO_FIELD;
                        w_req.stop_is_end = 1'b1;
                    end else if (!w_space) begin
                        n_base    = w_base_mode;
                        n_limited = r_width_given;
                        n_wleft   = r_field_width;
                        n_neg     = 1'b0;
                        n_acc     = '0;
                        n_any     = 1'b0;
                        if (r_in_char == aifp_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = aifp_pkg::PH_MINUS;
                        end else if (r_in_char == aifp_pkg::CH_PLUS) begin
                            n_phase = aifp_pkg::PH_SIGN;
                        end else begin
                            w_do_begin = 1'b1;
                        end
                    end
                end
                aifp_pkg::PH_MINUS: begin
                    if (r_in_eof) begin
                        w_emit            = 1'b1;
                        w_req.status      = aifp_pkg::ST_NO_FIELD;
                        w_req.stop_is_end = 1'b1;
                    end else if (r_in_char == aifp_pkg::CH_PLUS) begin
                        n_phase = aifp_pkg::PH_SIGN;
                    end else begin
                        w_do_begin = 1'b1;
                    end
                end
                aifp_pkg::PH_SIGN: begin
                    if (r_in_eof) begin
                        w_emit            = 1'b1;
                        w_req.status      = aifp_pkg::ST_NO_FIELD;
                        w_req.stop_is_end = 1'b1;
                    end else begin
                        w_do_begin = 1'b1;
                    end
                end
                aifp_pkg::PH_PREFIX: begin
                    if (r_in_eof) begin
                        w_emit            = 1'b1;
                        w_req.status      = aifp_pkg::ST_OK;
                        w_req.stop_is_end = 1'b1;
                    end else if ((r_in_char | aifp_pkg::CASE_BIT) == aifp_pkg::CH_LOWER_X) begin
                        n_base  = aifp_pkg::BASE_HEX;
                        n_phase = aifp_pkg::PH_DIGITS;
                    end else begin
                        w_do_step = 1'b1;
                    end
                end
                aifp_pkg::PH_DIGITS: begin
                    if (r_in_eof) begin
                        w_emit            = 1'b1;
                        w_req.status      = r_any ? aifp_pkg::ST_OK : aifp_pkg::ST_NO_DIGITS;
                        w_req.stop_is_end = 1'b1;
                    end else begin
                        w_do_step = 1'b1;
                    end
                end
                default: begin
                    n_phase = aifp_pkg::PH_IDLE;
                end
            endcase

            // leading zero opens a prefix in auto and hex modes without a width
            if (w_do_begin) begin
                if (!n_limited && r_in_char == aifp_pkg::CH_ZERO &&
                    (r_base_mode == aifp_pkg::MODE_AUTO || r_base_mode == aifp_pkg::MODE_HEX)) begin
                    n_any = 1'b1;
                    if (r_base_mode == aifp_pkg::MODE_AUTO) begin
                        n_base = aifp_pkg::BASE_OCT;
                    end
                    n_phase = aifp_pkg::PH_PREFIX;
                end else begin
                    w_do_step = 1'b1;
                end
            end

            if (w_do_step) begin
                n_phase = aifp_pkg::PH_DIGITS;
                if ((n_limited && n_wleft == 8'd0) || !w_digit_ok) begin
                    w_emit          = 1'b1;
                    w_req.status    = n_any ? aifp_pkg::ST_OK : aifp_pkg::ST_NO_DIGITS;
                    w_req.stop_char = r_in_char;
                end else begin
                    n_acc = w_acc_next;
                    n_any = 1'b1;
                    if (n_limited) begin
                        n_wleft = n_wleft - 8'd1;
                        if (n_wleft == 8'd0) begin
                            w_emit            = 1'b1;
                            w_req.status      = aifp_pkg::ST_OK;
                            w_req.stop_is_end = 1'b1;
                        end
                    end
                end
            end

            w_req.negative = n_neg;
            if (w_emit) begin
                n_phase = aifp_pkg::PH_IDLE;
            end
        end
    end

    // result request register
    logic [VALUE_BITS-1:0] r_em_acc;
    aifp_pkg::t_emit_req   r_em_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
        end else if (w_em_free) begin
            r_em_valid <= w_in_adv && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && w_emit) begin
            r_em_acc <= n_acc;
            r_em_req <= w_req;
        end
    end

    // finishing and output register
    logic [aifp_pkg::VALUE_W-1:0] w_value;
    logic [aifp_pkg::VALUE_W-1:0] r_out_value;
    logic [7:0]                   r_out_stop;
    logic [1:0]                   r_out_status;
    logic                         r_out_end;

    aifp_final #(
        .VALUE_BITS (VALUE_BITS)
    ) u_final (
        .i_acc    (r_em_acc),
        .i_req    (r_em_req),
        .i_signed (r_signed_conv),
        .i_size   (r_result_size),
        .o_value  (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_em_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_em_valid && w_out_free) begin
            r_out_value  <= w_value;
            r_out_stop   <= r_em_req.stop_char;
            r_out_status <= r_em_req.status;
            r_out_end    <= r_em_req.stop_is_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_stop, r_out_value};
    assign o_m_tuser  = {r_out_end, r_out_status};

`ifndef SYNTHESIS
    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_adv && w_emit) |=> (r_phase == aifp_pkg::PH_IDLE))
        else $error("field did not restart after its result");

    a_prefix_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == aifp_pkg::PH_PREFIX) |-> r_any)
        else $error("prefix state without consumed zero");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] != aifp_pkg::ST_OK) |-> (o_m_tdata[63:0] == 64'd0))
        else $error("failed conversion carries a value");

    a_no_field_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] == aifp_pkg::ST_NO_FIELD)
            |-> (o_m_tuser[2] && o_m_tdata[71:64] == 8'd0))
        else $error("missing field word without end flag");
`endif

endmodule
